>>> hw/rtl/cmo_pkg.sv
`default_nettype none

package cmo_pkg;

    // Fixed field widths of the request and result items.
    localparam int PRICE_IN_W = 32;
    localparam int WINDOW_W   = 9;
    localparam int VALUE_W    = 16;
    localparam int QUOT_W     = 16;
    localparam int BIT_IDX_W  = 4;

    // Window length after reset.
    localparam int WINDOW_RESET = 14;

    // 100 percent times 256, fed to the divider one bit at a time.
    localparam logic [QUOT_W-1:0] SCALE_X256 = 16'd25600;

    typedef struct packed {
        logic                  candle_present;
        logic [PRICE_IN_W-1:0] open_price;
        logic [PRICE_IN_W-1:0] close_price;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] oscillator_value;
        logic                      no_movement;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/cmo_addsub.sv
`default_nettype none

// Shared adder and subtractor. In subtract mode the carry out is high
// when a is not below b.
module cmo_addsub #(
    parameter int WIDTH = 41
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic             sub,
    output logic      [WIDTH-1:0] sum,
    output logic                  carry
);

    logic [WIDTH-1:0] b_eff;
    logic [WIDTH:0]   full;

    assign b_eff = sub ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
    assign sum   = full[WIDTH-1:0];
    assign carry = full[WIDTH];

endmodule

`default_nettype wire

>>> hw/rtl/cmo_ring.sv
`default_nettype none

// Move history: one write port and one registered read port.
module cmo_ring #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 33,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/chande_momentum_oscillator.sv
`default_nettype none

// Channel   Handshake              Payload
// item      item_valid/item_stall  cmo_pkg::item_t   (candle slot in)
// result    result_valid/result_stall cmo_pkg::result_t (oscillator out)
// cfg       cfg_valid/cfg_ready    cfg_data, window_length (always ready)
//
// From acceptance to the result register, one shared adder/subtractor does
// the move, the sum updates and a restoring division of 16 quotient bits,
// two steps more for each set bit of 25600. The sequencer is idle again as
// the result is loaded, so the next request can be taken in the following
// cycle.
// After reset and after every window_length write, a clearing pass writes
// zero into all MAX_WINDOW history entries, one per cycle, and no request is
// taken meanwhile. item_stall is high whenever the sequencer is not idle.
// A finished result waits in the output register while the next request runs.
module chande_momentum_oscillator #(
    parameter int MAX_WINDOW = 256,
    parameter int PRICE_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire cmo_pkg::item_t                    item,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output cmo_pkg::result_t                       result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cmo_pkg::WINDOW_W-1:0]      cfg_data
);

    import cmo_pkg::*;

    // Index width of the ring; the sums hold a full window of largest moves.
    localparam int IDX_W     = $clog2(MAX_WINDOW);
    localparam int SUM_W     = PRICE_BITS + IDX_W;
    localparam int UNIT_W    = SUM_W + 1;
    localparam int ENTRY_W   = PRICE_BITS + 1;
    localparam int RESET_WIN = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_WINDOW - 1);
    localparam logic [IDX_W-1:0] RESET_IDX = IDX_W'(RESET_WIN - 1);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOVE  = 4'd2;
    localparam logic [3:0] S_MAG   = 4'd3;
    localparam logic [3:0] S_OLD   = 4'd4;
    localparam logic [3:0] S_NEW   = 4'd5;
    localparam logic [3:0] S_TOT   = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_SWAP  = 4'd8;
    localparam logic [3:0] S_DIVA  = 4'd9;
    localparam logic [3:0] S_DIVB1 = 4'd10;
    localparam logic [3:0] S_DIVB2 = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // Control state.
    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]      w_last_reg, w_last_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [SUM_W-1:0]      up_reg, up_next;
    logic [SUM_W-1:0]      down_reg, down_next;
    logic [PRICE_BITS-1:0] last_close_reg, last_close_next;
    logic                  last_present_reg, last_present_next;
    logic                  result_valid_reg, result_valid_next;

    // Working payload.
    item_t                 item_reg, item_next;
    logic [PRICE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [SUM_W-1:0]      den_reg, den_next;
    logic [SUM_W-1:0]      num_reg, num_next;
    logic [UNIT_W-1:0]     rem_reg, rem_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic [BIT_IDX_W-1:0]  bit_reg, bit_next;
    logic                  up_wins_reg, up_wins_next;
    logic                  no_move_reg, no_move_next;
    result_t               result_reg, result_next;

    // Shared unit.
    logic [UNIT_W-1:0]     unit_a, unit_b, unit_sum;
    logic                  unit_sub, unit_carry;

    // Ring ports.
    logic                  ring_wr_en;
    logic [IDX_W-1:0]      ring_wr_addr;
    logic [ENTRY_W-1:0]    ring_wr_data;
    logic [ENTRY_W-1:0]    ring_rd_data;

    logic [PRICE_BITS-1:0] open_p, close_p, base_p;
    logic [PRICE_BITS-1:0] old_mag;
    logic                  old_neg;
    logic                  cfg_write;
    logic [IDX_W-1:0]      cfg_last;

    // Prices are cut or widened to the configured price width.
    assign open_p  = PRICE_BITS'(item_reg.open_price);
    assign close_p = PRICE_BITS'(item_reg.close_price);
    assign base_p  = last_present_reg ? last_close_reg : open_p;

    // History entries hold sign and magnitude of a move.
    assign old_neg = ring_rd_data[ENTRY_W-1];
    assign old_mag = ring_rd_data[PRICE_BITS-1:0];

    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A window length of zero acts as one, and anything above the ring size
    // acts as the ring size.
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cfg_last = '0;
        end
        else if (32'(cfg_data) > 32'(MAX_WINDOW))
        begin
            cfg_last = LAST_IDX;
        end
        else
        begin
            cfg_last = IDX_W'(32'(cfg_data) - 32'd1);
        end
    end

    cmo_addsub #(
        .WIDTH (UNIT_W)
    ) u_addsub (
        .a     (unit_a),
        .b     (unit_b),
        .sub   (unit_sub),
        .sum   (unit_sum),
        .carry (unit_carry)
    );

    cmo_ring #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_addr (pos_reg),
        .rd_data (ring_rd_data)
    );

    // Operand selection for the shared unit, one operation per state.
    always_comb
    begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
        unique case (state_reg)
            S_MOVE:
            begin
                unit_a   = UNIT_W'(close_p);
                unit_b   = UNIT_W'(base_p);
                unit_sub = 1'b1;
            end
            S_MAG:
            begin
                unit_a   = UNIT_W'(base_p);
                unit_b   = UNIT_W'(close_p);
                unit_sub = 1'b1;
            end
            S_OLD:
            begin
                unit_a   = UNIT_W'(old_neg ? down_reg : up_reg);
                unit_b   = UNIT_W'(old_mag);
                unit_sub = 1'b1;
            end
            S_NEW:
            begin
                unit_a   = UNIT_W'(neg_reg ? down_reg : up_reg);
                unit_b   = UNIT_W'(mag_reg);
                unit_sub = 1'b0;
            end
            S_TOT:
            begin
                unit_a   = UNIT_W'(up_reg);
                unit_b   = UNIT_W'(down_reg);
                unit_sub = 1'b0;
            end
            S_CMP:
            begin
                unit_a   = UNIT_W'(up_reg);
                unit_b   = UNIT_W'(down_reg);
                unit_sub = 1'b1;
            end
            S_SWAP:
            begin
                unit_a   = UNIT_W'(down_reg);
                unit_b   = UNIT_W'(up_reg);
                unit_sub = 1'b1;
            end
            S_DIVA:
            begin
                unit_a   = {rem_reg[UNIT_W-2:0], 1'b0};
                unit_b   = UNIT_W'(den_reg);
                unit_sub = 1'b1;
            end
            S_DIVB1:
            begin
                unit_a   = rem_reg;
                unit_b   = UNIT_W'(num_reg);
                unit_sub = 1'b0;
            end
            S_DIVB2:
            begin
                unit_a   = rem_reg;
                unit_b   = UNIT_W'(den_reg);
                unit_sub = 1'b1;
            end
            default:
            begin
                unit_a   = '0;
                unit_b   = '0;
                unit_sub = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        w_last_next       = w_last_reg;
        pos_next          = pos_reg;
        up_next           = up_reg;
        down_next         = down_reg;
        last_close_next   = last_close_reg;
        last_present_next = last_present_reg;
        result_valid_next = result_valid_reg;
        item_next         = item_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        den_next          = den_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        bit_next          = bit_reg;
        up_wins_next      = up_wins_reg;
        no_move_next      = no_move_reg;
        result_next       = result_reg;
        ring_wr_en        = 1'b0;
        ring_wr_addr      = pos_reg;
        ring_wr_data      = {neg_reg, mag_reg};

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ring_wr_en   = 1'b1;
                ring_wr_addr = clr_cnt_reg;
                ring_wr_data = '0;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (item_reg.candle_present)
                begin
                    mag_next = unit_sum[PRICE_BITS-1:0];
                    neg_next = !unit_carry;
                    if (unit_carry)
                    begin
                        last_close_next   = close_p;
                        last_present_next = 1'b1;
                        state_next        = S_OLD;
                    end
                    else
                    begin
                        state_next = S_MAG;
                    end
                end
                else
                begin
                    mag_next          = '0;
                    neg_next          = 1'b0;
                    last_present_next = 1'b0;
                    state_next        = S_OLD;
                end
            end
            S_MAG:
            begin
                mag_next          = unit_sum[PRICE_BITS-1:0];
                last_close_next   = close_p;
                last_present_next = 1'b1;
                state_next        = S_OLD;
            end
            S_OLD:
            begin
                if (old_mag != '0)
                begin
                    if (old_neg)
                    begin
                        down_next = unit_sum[SUM_W-1:0];
                    end
                    else
                    begin
                        up_next = unit_sum[SUM_W-1:0];
                    end
                end
                state_next = S_NEW;
            end
            S_NEW:
            begin
                ring_wr_en = 1'b1;
                if (mag_reg != '0)
                begin
                    if (neg_reg)
                    begin
                        down_next = unit_sum[SUM_W-1:0];
                    end
                    else
                    begin
                        up_next = unit_sum[SUM_W-1:0];
                    end
                end
                pos_next   = (pos_reg == w_last_reg) ? '0 : pos_reg + 1'b1;
                state_next = S_TOT;
            end
            S_TOT:
            begin
                den_next   = unit_sum[SUM_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                num_next     = unit_sum[SUM_W-1:0];
                up_wins_next = unit_carry;
                rem_next     = '0;
                quot_next    = '0;
                bit_next     = BIT_IDX_W'(QUOT_W - 1);
                no_move_next = 1'b0;
                priority if (den_reg == '0)
                begin
                    no_move_next = 1'b1;
                    up_wins_next = 1'b1;
                    state_next   = S_OUT;
                end
                else if (unit_carry)
                begin
                    state_next = S_DIVA;
                end
                else
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                num_next   = unit_sum[SUM_W-1:0];
                state_next = S_DIVA;
            end
            S_DIVA:
            begin
                rem_next  = unit_carry ? unit_sum : {rem_reg[UNIT_W-2:0], 1'b0};
                quot_next = {quot_reg[QUOT_W-2:0], unit_carry};
                priority if (SCALE_X256[bit_reg])
                begin
                    state_next = S_DIVB1;
                end
                else if (bit_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            S_DIVB1:
            begin
                rem_next   = unit_sum;
                state_next = S_DIVB2;
            end
            S_DIVB2:
            begin
                if (unit_carry)
                begin
                    rem_next  = unit_sum;
                    quot_next = quot_reg + 1'b1;
                end
                if (bit_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_DIVA;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next            = 1'b1;
                    result_next.no_movement      = no_move_reg;
                    result_next.oscillator_value = up_wins_reg ? $signed(quot_reg)
                                                               : -$signed(quot_reg);
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // A window length write restarts the history with a clearing pass.
        if (cfg_write)
        begin
            w_last_next  = cfg_last;
            up_next      = '0;
            down_next    = '0;
            pos_next     = '0;
            clr_cnt_next = '0;
            state_next   = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            w_last_reg       <= RESET_IDX;
            pos_reg          <= '0;
            up_reg           <= '0;
            down_reg         <= '0;
            last_close_reg   <= '0;
            last_present_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            w_last_reg       <= w_last_next;
            pos_reg          <= pos_next;
            up_reg           <= up_next;
            down_reg         <= down_next;
            last_close_reg   <= last_close_next;
            last_present_reg <= last_present_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        bit_reg     <= bit_next;
        up_wins_reg <= up_wins_next;
        no_move_reg <= no_move_next;
        result_reg  <= result_next;
    end

    // A new result only appears out of the output state.
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

    // The ring pointer never passes the active window.
    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= w_last_reg)
        else $error("ring position beyond window");

    // With no movement the value is forced to zero.
    a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.no_movement) |-> (result.oscillator_value == '0))
        else $error("nonzero value with no movement");

    // The oscillator stays within plus and minus 100 percent.
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.oscillator_value <= 16'sd25600) &&
                         (result.oscillator_value >= -16'sd25600))
        else $error("oscillator value out of range");

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

// Checks the Chande momentum oscillator block against an independent prediction.
// Each accepted candle slot is passed to a tracker. The tracker keeps its own
// ring of moves and its own running up and down sums, and it queues the
// reading that the slot must produce. Each reading that the block delivers
// is compared, field by field, with the oldest queued reading.
module testbench;
    import cmo_pkg::*;

    localparam int          HISTORY_DEPTH = 256;
    // Covers the longest request, with a margin for the handoff through the
    // output register.
    localparam int          DRAIN_CYCLES  = 40;
    // The limit leaves room for the slowest correct run, even counting the
    // clearing pass that follows every window write.
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned REPORT_LIMIT  = 10;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    item_t               item;
    logic                result_valid;
    logic                result_stall;
    result_t             result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [WINDOW_W-1:0] cfg_data;

    // When a steady flag is set, that side runs with no idle cycles for the
    // whole phase. This gives back-to-back stretches between the random gaps.
    bit                  steady_source;
    bit                  steady_sink;
    logic [31:0]         walk_close;
    int unsigned         cycle_count = 0;

    // The tracker mirrors the block's state. It is the window register, the
    // ring of signed moves, both running sums and the last candle seen. It
    // also holds the readings that are still owed by the block.
    class oscillator_tracker;
        logic [WINDOW_W-1:0] window_length;
        longint              move_log [HISTORY_DEPTH];
        longint unsigned     up_total;
        longint unsigned     down_total;
        logic [31:0]         last_close;
        bit                  last_present;
        int unsigned         ring_slot;
        result_t             owed_readings [$];
        int unsigned         mismatch_count;
        int unsigned         reading_count;

        function new();
            window_length = WINDOW_W'(WINDOW_RESET);
            clear_moves();
            last_close = '0;
            last_present = 1'b0;
            mismatch_count = 0;
            reading_count = 0;
        endfunction

        // A window write empties the ring and the sums. The last candle is
        // kept, so the next move still refers to its close.
        function void clear_moves();
            foreach (move_log[i])
                move_log[i] = 0;
            up_total = 0;
            down_total = 0;
            ring_slot = 0;
        endfunction

        function void set_window(logic [WINDOW_W-1:0] value);
            window_length = value;
            clear_moves();
        endfunction

        function void report(string note);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("reading %0d: %s", reading_count, note);
        endfunction

        // Steps the mirrored state by one slot and queues the reading that
        // the slot must produce.
        function void log_slot(item_t s);
            int unsigned     span;
            logic [31:0]     base;
            longint          move;
            longint          old;
            longint unsigned total;
            longint unsigned diff;
            longint unsigned mag;
            logic [15:0]     mag16;
            result_t         r;

            // A window of zero acts as one. A window above the ring size
            // acts as the full ring.
            if (window_length == 0)
                span = 1;
            else if (window_length > HISTORY_DEPTH)
                span = HISTORY_DEPTH;
            else
                span = window_length;
            if (ring_slot >= span)
                ring_slot = 0;

            // An empty slot enters a zero move and breaks the chain of
            // closes. A candle that follows an empty slot is measured from
            // its own open price.
            move = 0;
            if (s.candle_present)
            begin
                base = last_present ? last_close : s.open_price;
                move = longint'({32'd0, s.close_price}) - longint'({32'd0, base});
                last_close = s.close_price;
                last_present = 1'b1;
            end
            else
                last_present = 1'b0;

            old = move_log[ring_slot];
            if (old > 0)
                up_total -= longint'(old);
            else if (old < 0)
                down_total -= longint'(-old);
            move_log[ring_slot] = move;
            if (move > 0)
                up_total += longint'(move);
            else if (move < 0)
                down_total += longint'(-move);
            ring_slot++;
            if (ring_slot >= span)
                ring_slot = 0;

            total = up_total + down_total;
            r.no_movement = (total == 0);
            r.oscillator_value = '0;
            if (total != 0)
            begin
                diff = (up_total >= down_total) ? up_total - down_total
                                                : down_total - up_total;
                // The sums stay below 2^41, so the scaled numerator fits in
                // 64 bits. Flooring the magnitude truncates toward zero.
                mag = (diff * SCALE_X256) / total;
                mag16 = mag[15:0];
                r.oscillator_value = (up_total >= down_total) ? mag16 : -mag16;
            end
            owed_readings.push_back(r);
        endfunction

        function void check_reading(result_t got);
            result_t want;

            reading_count++;
            if (owed_readings.size() == 0)
            begin
                report($sformatf("unexpected reading, value %0d, no_movement %0b",
                                 got.oscillator_value, got.no_movement));
                return;
            end
            want = owed_readings.pop_front();
            if (got.oscillator_value !== want.oscillator_value)
                report($sformatf("oscillator_value expected %0d, got %0d",
                                 want.oscillator_value, got.oscillator_value));
            if (got.no_movement !== want.no_movement)
                report($sformatf("no_movement expected %0b, got %0b",
                                 want.no_movement, got.no_movement));
        endfunction

        function int unsigned pending();
            return owed_readings.size();
        endfunction

        function bit failed();
            return (mismatch_count != 0) || (owed_readings.size() != 0);
        endfunction
    endclass

    oscillator_tracker tracker = new();

    chande_momentum_oscillator #(
        .MAX_WINDOW (HISTORY_DEPTH),
        .PRICE_BITS (PRICE_IN_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // The watchdog. A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("chande_momentum_oscillator verification failed");
            $finish;
        end
    end

    // The readings are sampled at the rising edge, before the block's own
    // updates of that edge take effect.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_reading(result);
    end

    // Most idle stretches are short. About one draw in ten gives one long enough
    // to back up the block's output register.
    function automatic int unsigned idle_length(bit steady);
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (steady || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // The receiver stalls at random after reset, in runs of random length.
    initial
    begin
        int unsigned hold;

        result_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            hold = idle_length(steady_sink);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
        end
    end

    function automatic logic [31:0] corner_price();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            3: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic item_t candle(bit present, logic [31:0] open_p, logic [31:0] close_p);
        item_t s;

        s.candle_present = present;
        s.open_price = open_p;
        s.close_price = close_p;
        return s;
    endfunction

    // Most random slots follow a price walk with steps of random scale, so
    // that the sums mix up and down moves as real data would. The remaining
    // slots are empty slots, corner prices, repeated closes and fully
    // random prices.
    function automatic item_t random_slot();
        item_t       s;
        int unsigned pick;
        logic [31:0] step;

        pick = $urandom_range(0, 99);
        s = candle(1'b1, $urandom, $urandom);
        if (pick < 10)
            s.candle_present = 1'b0;
        else if (pick < 16)
        begin
            s.open_price = corner_price();
            s.close_price = corner_price();
        end
        else if (pick < 24)
        begin
            s.open_price = walk_close;
            s.close_price = walk_close;
        end
        else if (pick >= 34)
        begin
            step = $urandom_range(0, 1 << $urandom_range(0, 20));
            s.close_price = $urandom_range(0, 1) ? walk_close + step : walk_close - step;
            s.open_price = s.close_price + $urandom_range(0, 200) - 100;
        end
        // Picks from 24 to 33 keep the fully random prices.
        if (s.candle_present)
            walk_close = s.close_price;
        return s;
    endfunction

    // Each driving task is entered at a falling edge and returns at one. After
    // a request is accepted, item_valid stays high. The caller either drives the
    // next request in the same step or lowers item_valid.
    task automatic send_slot(input item_t s);
        int unsigned gap;

        gap = idle_length(steady_source);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= s;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        tracker.log_slot(s);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tracker.pending() != 0);
    endtask

    // The window register is written only once the block is idle. Every
    // reading has to be in, and the last request has to have left the
    // datapath.
    task automatic program_window(input logic [WINDOW_W-1:0] value);
        item_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_window(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Each phase runs under its own window. Halfway through, the sender holds
    // back until the block has delivered every reading that it owes.
    task automatic run_phase(input logic [WINDOW_W-1:0] value, input int unsigned count);
        program_window(value);
        steady_source = ($urandom_range(0, 3) == 0);
        steady_sink = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                item_valid <= 1'b0;
                wait_drained();
            end
            send_slot(random_slot());
        end
    endtask

    initial
    begin
        logic [WINDOW_W-1:0] windows [10];

        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        steady_source = 1'b0;
        steady_sink = 1'b0;
        walk_close = 32'd1_000_000;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The directed slots run under the reset window of 14. They cover
        // empty slots and candles with no earlier candle. They also cover
        // full-scale moves up and down, equal prices both with and without
        // a previous close, and alternating bit patterns. The run is long
        // enough for the big early moves to leave the window.
        send_slot(candle(1'b0, 32'h0000_0000, 32'h0000_0000));
        send_slot(candle(1'b1, 32'h0000_0000, 32'h0000_0000));
        send_slot(candle(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_slot(candle(1'b1, 32'h0000_0000, 32'h0000_0000));
        send_slot(candle(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_slot(candle(1'b1, 32'hFFFF_FFFF, 32'h0000_0000));
        send_slot(candle(1'b1, 32'h0000_0005, 32'h0000_0000));
        send_slot(candle(1'b1, 32'h0000_03E8, 32'h0000_03EB));
        send_slot(candle(1'b1, 32'h0000_03EB, 32'h0000_03E8));
        send_slot(candle(1'b0, 32'h5555_5555, 32'hAAAA_AAAA));
        send_slot(candle(1'b1, 32'h0000_0007, 32'h0000_0007));
        send_slot(candle(1'b1, 32'h0000_0000, 32'h8000_0000));
        send_slot(candle(1'b1, 32'h5555_5555, 32'hAAAA_AAAA));
        send_slot(candle(1'b1, 32'hAAAA_AAAA, 32'h5555_5555));
        for (int unsigned i = 0; i < 6; i++)
            send_slot(candle(1'b1, 32'h0000_0000, 32'h5555_5555 + i * 3));

        // The phases visit both window extremes. They also visit a window of
        // zero, two windows above the ring size with all bits set once, and
        // several ordinary windows.
        windows[0] = 9'd1;
        windows[1] = 9'd0;
        windows[2] = 9'd256;
        windows[3] = 9'd511;
        windows[4] = 9'd2;
        windows[5] = WINDOW_W'($urandom_range(3, 30));
        windows[6] = WINDOW_W'($urandom_range(3, 30));
        windows[7] = 9'd257;
        windows[8] = WINDOW_W'($urandom_range(31, 255));
        windows[9] = 9'd3;
        foreach (windows[p])
            run_phase(windows[p], (windows[p] >= HISTORY_DEPTH) ? 300 : 120);

        item_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!tracker.failed())
            $display("chande_momentum_oscillator verification clean");
        else
            $display("chande_momentum_oscillator verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> chande_momentum_oscillator.f
hw/rtl/cmo_pkg.sv
hw/rtl/cmo_addsub.sv
hw/rtl/cmo_ring.sv
hw/rtl/chande_momentum_oscillator.sv
sim/testbench.sv
